>>> rtl/vze_pkg.sv
`default_nettype none

package vze_pkg;

  localparam int VALUE_W   = 64;
  localparam int HALF_W    = 32;
  localparam int GROUP_W   = 7;
  localparam int BYTE_W    = 8;
  localparam int MAX_BYTES = 10;
  localparam int CNT_W     = 4;

  localparam logic [BYTE_W-1:0] LOW7 = 8'h7F;
  localparam logic [BYTE_W-1:0] CONT = 8'h80;

  // Masks to the selected width and applies the zigzag map when signed.
  function automatic logic [VALUE_W-1:0] map_value(input logic [VALUE_W-1:0] v,
                                                   input logic sgn,
                                                   input logic wide);
    logic [VALUE_W-1:0] m;
    logic [HALF_W-1:0]  z32;
    logic [VALUE_W-1:0] res;
    m   = wide ? v : {{(VALUE_W-HALF_W){1'b0}}, v[HALF_W-1:0]};
    z32 = {m[HALF_W-2:0], 1'b0} ^ {HALF_W{m[HALF_W-1]}};
    if (!sgn) begin
      res = m;
    end else if (wide) begin
      res = {m[VALUE_W-2:0], 1'b0} ^ {VALUE_W{m[VALUE_W-1]}};
    end else begin
      res = {{(VALUE_W-HALF_W){1'b0}}, z32};
    end
    return res;
  endfunction

  // Number of varint bytes: index of the highest nonzero 7-bit group plus one.
  function automatic logic [CNT_W-1:0] byte_count(input logic [VALUE_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = CNT_W'(1);
    for (int g = 1; g < MAX_BYTES - 1; g++) begin
      if (v[g*GROUP_W +: GROUP_W] != '0) begin
        n = CNT_W'(g + 1);
      end
    end
    if (v[VALUE_W-1]) begin
      n = CNT_W'(MAX_BYTES);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/varint_zigzag_encoder.sv
`default_nettype none

// Base-128 varint encoder with optional zigzag mapping.
// Input channel: in_valid/in_stall carry one word holding a 64-bit value,
// a signed flag and a width flag. A word is taken at a rising edge where
// in_valid is high and in_stall is low. In 32-bit mode bits 63..32 are
// ignored; a signed value is zigzag mapped at the selected width.
// Output channel: out_valid/out_stall carry one varint byte per word, low
// seven bits first, with out_last on the final byte of each value.
// Pipeline: stage one masks and maps the value, stage two counts the bytes,
// stage three is a shift register that sends one byte per cycle while out_stall
// is low. A word reaches stage three through stage one and then stage two.
// A value takes 1 to 5 output bytes in 32-bit mode and 1 to 10 in 64-bit
// mode; the byte serializer in stage three sets the sustained rate, and the
// two front stages keep taking new words while it is busy, until both are full.
// When the receiver raises out_stall the current byte holds, and the
// front stages fill and then raise in_stall. Reset empties every stage.
module varint_zigzag_encoder (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [vze_pkg::VALUE_W-1:0] in_value,
  input  wire logic                       in_is_signed,
  input  wire logic                       in_wide_mode,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [vze_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_last
);

  // Stage one: mapped value.
  logic                         s1_vld_r;
  logic [vze_pkg::VALUE_W-1:0]  s1_val_r;
  // Stage two: mapped value and its byte count.
  logic                         s2_vld_r;
  logic [vze_pkg::VALUE_W-1:0]  s2_val_r;
  logic [vze_pkg::CNT_W-1:0]    s2_cnt_r;
  // Stage three: serializer.
  logic                         s3_vld_r;
  logic [vze_pkg::VALUE_W-1:0]  sh_r;
  logic [vze_pkg::CNT_W-1:0]    rem_r;

  logic s3_free, s2_free, s1_free, out_take;

  assign out_take = s3_vld_r && !out_stall;
  // The serializer frees up as the last byte of its value is taken.
  assign s3_free  = !s3_vld_r || (out_take && out_last);
  assign s2_free  = !s2_vld_r || s3_free;
  assign s1_free  = !s1_vld_r || s2_free;
  assign in_stall = !s1_free;

  assign out_valid = s3_vld_r;
  assign out_last  = (rem_r == vze_pkg::CNT_W'(1));
  assign out_byte  = (out_last ? '0 : vze_pkg::CONT)
                   | ({1'b0, sh_r[vze_pkg::GROUP_W-1:0]} & vze_pkg::LOW7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_vld_r <= in_valid;
      end
      if (s2_free) begin
        s2_vld_r <= s1_vld_r;
      end
      if (s3_free) begin
        s3_vld_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_val_r <= vze_pkg::map_value(in_value, in_is_signed, in_wide_mode);
    end
    if (s2_free && s1_vld_r) begin
      s2_val_r <= s1_val_r;
      s2_cnt_r <= vze_pkg::byte_count(s1_val_r);
    end
    if (s3_free) begin
      if (s2_vld_r) begin
        sh_r  <= s2_val_r;
        rem_r <= s2_cnt_r;
      end
    end else if (out_take) begin
      sh_r  <= sh_r >> vze_pkg::GROUP_W;
      rem_r <= rem_r - vze_pkg::CNT_W'(1);
    end
  end

  // The byte count in stage two always lies between one and the maximum.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (s2_cnt_r != '0) && (s2_cnt_r <= vze_pkg::CNT_W'(vze_pkg::MAX_BYTES)))
    else $error("byte count out of range");

  // A byte is the last one exactly when no higher bits remain to send.
  a_last_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((sh_r[vze_pkg::VALUE_W-1:vze_pkg::GROUP_W] == '0) == out_last))
    else $error("last flag disagrees with remaining bits");

  // Taking a middle byte keeps the serializer busy and counts it down.
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !out_last) |=>
      (out_valid && (rem_r == $past(rem_r) - vze_pkg::CNT_W'(1))))
    else $error("serializer lost or skipped a byte");

  // With nothing waiting in stage two, the output empties after a last byte.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && out_last && !s2_vld_r) |=> !out_valid)
    else $error("output valid after final byte with empty pipeline");

endmodule

`default_nettype wire
